[src/detent_snap_position_controller_assert.svh]
// assertion macros for the detent snap position controller
`ifndef DETENT_SNAP_POSITION_CONTROLLER_ASSERT_SVH
`define DETENT_SNAP_POSITION_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define DSPC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dspc assertion failed");
`define DSPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dspc assertion failed");
`else
`define DSPC_ASSERT_IMPL(lbl, ante, cons)
`define DSPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/dspc_pkg.sv]
// shared types and constants of the detent snap position controller
package dspc_pkg;

	localparam int MAX_SNAPS_DEF   = 6;
	localparam int ANGLE_WIDTH_DEF = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_SNAP_A      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_B      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_C      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_COUNT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd7;

	localparam logic [6:0] SPEED_LIMIT_RESET = 7'd127;

	// controller to datapath
	typedef struct packed {
		logic cap;
		logic eval;
		logic scan;
		logic err;
		logic mul;
		logic load;
	} dspc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pass;
		logic latch;
		logic hold;
		logic scan_last;
	} dspc_stat_t;

endpackage

[src/dspc_if.sv]
// tick and drive channel interfaces
interface dspc_in_if;
	logic              valid;
	logic              ready;
	logic              enable;
	logic signed [7:0] manual;
	logic signed [31:0] position;

	modport source (output valid, enable, manual, position, input ready);
	modport sink (input valid, enable, manual, position, output ready);
endinterface

interface dspc_out_if;
	logic               valid;
	logic               ready;
	logic signed [7:0]  motor_cmd;
	logic               target_valid;
	logic signed [31:0] target_angle;

	modport source (output valid, motor_cmd, target_valid, target_angle, input ready);
	modport sink (input valid, motor_cmd, target_valid, target_angle, output ready);
endinterface

[src/detent_snap_position_controller.sv]
// top level of the detent snap position controller
//
// tick: one word per control tick (enable, manual, position); drive: one word
// back per tick (motor_cmd, target_valid, target_angle). Both are valid/ready.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), written
// only while no tick is in flight, which the user must ensure as the block does
// not enforce it; registers take effect on the next tick. Steps per tick:
//   pass-through, or enabled with no target: capture, evaluate, load
//   holding a latched target: also error, gain multiply, clamp before the load
//   first tick after release: also a snap scan over n = active snap count, which
//   compares one table entry a cycle against the position
// The drive word becomes valid the cycle after it is loaded. One tick is in
// work at a time; the next tick is taken once the previous word is loaded,
// even if the receiver has not yet taken it. A stalled receiver holds the
// word and, after the following tick's work, stalls acceptance of ticks.
// Reset clears the latched target, the operator flag and the configuration
// (speed limit to 127, everything else to zero).
`include "detent_snap_position_controller_assert.svh"

module detent_snap_position_controller
	import dspc_pkg::*;
#(
	parameter int MAX_SNAPS   = MAX_SNAPS_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dspc_in_if.sink               tick,
	dspc_out_if.source            drive,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dspc_cmd_t  cmd;
	dspc_stat_t st;

	dspc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.out_valid (drive.valid),
		.out_ready (drive.ready),
		.st        (st),
		.cmd       (cmd)
	);

	dspc_dp #(
		.MAX_SNAPS   (MAX_SNAPS),
		.ANGLE_WIDTH (ANGLE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.enable       (tick.enable),
		.manual       (tick.manual),
		.position     (tick.position),
		.motor_cmd    (drive.motor_cmd),
		.target_valid (drive.target_valid),
		.target_angle (drive.target_angle)
	);

	`DSPC_ASSERT_NEXT(a_accept_eval, tick.valid && tick.ready, cmd.eval)
	`DSPC_ASSERT_NEXT(a_load_valid, cmd.load, drive.valid)
	`DSPC_ASSERT_NEXT(a_latch_holds, cmd.scan && st.scan_last, st.hold)
	`DSPC_ASSERT_IMPL(a_no_target_zero, drive.valid && !drive.target_valid,
		drive.target_angle == 32'sd0)
	`DSPC_ASSERT_IMPL(a_cmd_range, drive.valid, drive.motor_cmd != -8'sd128)

endmodule

[src/dspc_ctrl.sv]
// sequencing state machine of the detent snap position controller
module dspc_ctrl
	import dspc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dspc_stat_t st,
	output dspc_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_ERR  = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (st.pass)
					state_d = S_DONE;
				else if (st.latch)
					state_d = S_SCAN;
				else if (st.hold)
					state_d = S_ERR;
				else
					state_d = S_DONE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_last)
					state_d = S_ERR;
			end
			S_ERR: begin
				cmd.err = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[src/dspc_dp.sv]
// datapath: configuration, snap scan, error, gain multiply and output word
module dspc_dp
	import dspc_pkg::*;
#(
	parameter int MAX_SNAPS   = MAX_SNAPS_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dspc_cmd_t             cmd,
	output dspc_stat_t            st,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  enable,
	input  logic signed [7:0]     manual,
	input  logic signed [31:0]    position,
	output logic signed [7:0]     motor_cmd,
	output logic                  target_valid,
	output logic signed [31:0]    target_angle
);

	localparam int AW = ANGLE_WIDTH;
	localparam int IW = $clog2(MAX_SNAPS + 1);
	localparam int SW = (MAX_SNAPS > 1) ? $clog2(MAX_SNAPS) : 1;

	// configuration
	logic signed [AW-1:0] snap_q [MAX_SNAPS];
	logic [2:0]           snap_count_q;
	logic [23:0]          gain_q;
	logic [15:0]          tol_q;
	logic [6:0]           limit_q;
	logic [6:0]           deadband_q;

	// captured word and controller state
	logic                 en_q;
	logic signed [7:0]    man_q;
	logic signed [AW-1:0] pos_q;
	logic                 op_q;
	logic                 hold_q;
	logic signed [AW-1:0] target_q;

	// scan and drive
	logic signed [AW-1:0] best_q;
	logic [AW:0]          bestd_q;
	logic [IW-1:0]        idx_q;
	logic [AW:0]          err_q;
	logic                 dir_q;
	logic [46:0]          prod_q;
	logic                 big_q;
	logic                 small_q;
	logic                 drive_q;
	logic signed [7:0]    cmd_q;

	logic signed [7:0]    motor_q;
	logic                 tvalid_q;
	logic signed [31:0]   tangle_q;

	logic [7:0]           man_mag;
	logic                 pass;
	logic [2:0]           n_sat;
	logic [IW-1:0]        n;
	logic                 in_range;
	logic signed [AW-1:0] snap_rd;
	logic signed [AW:0]   sdiff;
	logic [AW:0]          sdist;
	logic signed [AW:0]   ediff;
	logic [63:0]          errx;
	logic [30:0]          mag_full;
	logic [6:0]           mag_sel;
	logic signed [7:0]    drive_val;
	logic signed [7:0]    man_sat;

	genvar j;
	generate
		for (j = 0; j < MAX_SNAPS; j++) begin : g_snap
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					snap_q[j] <= '0;
				else if (cfg_we && cfg_index == CFG_IDX_W'(REG_SNAP_A + (j / 2)))
					snap_q[j] <= cfg_data[(j % 2) * 32 +: AW];
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_count_q <= '0;
			gain_q       <= '0;
			tol_q        <= '0;
			limit_q      <= SPEED_LIMIT_RESET;
			deadband_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SNAP_COUNT:  snap_count_q <= cfg_data[2:0];
				REG_GAIN:        gain_q       <= cfg_data[23:0];
				REG_TOLERANCE:   tol_q        <= cfg_data[15:0];
				REG_SPEED_LIMIT: limit_q      <= cfg_data[6:0];
				REG_DEADBAND:    deadband_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign man_mag = man_q[7] ? (8'd0 - 8'(man_q)) : 8'(man_q);
	assign pass    = !en_q || (man_mag > {1'b0, deadband_q});
	assign man_sat = (man_q == -8'sd128) ? -8'sd127 : man_q;

	assign n_sat    = (snap_count_q > 3'(MAX_SNAPS)) ? 3'(MAX_SNAPS) : snap_count_q;
	assign n        = IW'(n_sat);
	assign in_range = (idx_q < n);
	assign snap_rd  = snap_q[idx_q[SW-1:0]];
	assign sdiff    = {snap_rd[AW-1], snap_rd} - {pos_q[AW-1], pos_q};
	assign sdist    = sdiff[AW] ? (AW+1)'(-sdiff) : (AW+1)'(sdiff);

	assign ediff = {target_q[AW-1], target_q} - {pos_q[AW-1], pos_q};
	assign errx  = 64'(err_q);

	assign st.pass      = pass;
	assign st.latch     = op_q;
	assign st.hold      = hold_q;
	assign st.scan_last = !in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= 1'b0;
			hold_q   <= 1'b0;
			target_q <= '0;
		end else begin
			if (cmd.eval) begin
				if (!en_q) begin
					op_q   <= 1'b0;
					hold_q <= 1'b0;
				end else if (pass) begin
					op_q   <= 1'b1;
					hold_q <= 1'b0;
				end
			end
			if (cmd.scan && !in_range) begin
				target_q <= best_q;
				hold_q   <= 1'b1;
				op_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			en_q  <= enable;
			man_q <= manual;
			pos_q <= position[AW-1:0];
		end
		if (cmd.eval) begin
			cmd_q   <= pass ? man_sat : 8'sd0;
			drive_q <= !pass && (op_q || hold_q);
			// empty table leaves the current position as the winner
			best_q  <= pos_q;
			bestd_q <= '1;
			idx_q   <= '0;
		end
		if (cmd.scan && in_range) begin
			if (sdist < bestd_q) begin
				best_q  <= snap_rd;
				bestd_q <= sdist;
			end
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.err) begin
			err_q <= ediff[AW] ? (AW+1)'(-ediff) : (AW+1)'(ediff);
			dir_q <= !ediff[AW];
		end
		if (cmd.mul) begin
			prod_q  <= 47'(gain_q) * 47'(errx[22:0]);
			big_q   <= |errx[63:23];
			small_q <= (errx <= 64'(tol_q));
		end
		if (cmd.load) begin
			motor_q  <= drive_q ? drive_val : cmd_q;
			tvalid_q <= hold_q;
			tangle_q <= hold_q ? 32'(target_q) : 32'sd0;
		end
	end

	// an error of 2^23 or more already drives past any limit once gain is non-zero
	assign mag_full  = prod_q[46:16];
	assign mag_sel   = ((big_q && gain_q != 24'd0) || mag_full > 31'(limit_q)) ?
		limit_q : mag_full[6:0];
	assign drive_val = small_q ? 8'sd0 :
		(dir_q ? $signed({1'b0, mag_sel}) : -$signed({1'b0, mag_sel}));

	assign motor_cmd    = motor_q;
	assign target_valid = tvalid_q;
	assign target_angle = tangle_q;

endmodule
